@@ sv/tbgd_pkg.sv @@
// Shared types and constants for the two-button gesture decoder.
package tbgd_pkg;

  localparam int unsigned LEVEL_COUNT       = 6;
  localparam int unsigned TICK_COUNTER_BITS = 12;
  localparam int unsigned LEVEL_BITS        = $clog2(LEVEL_COUNT);
  localparam int unsigned THRESH_BITS       = 12;
  localparam int unsigned DUTY_BITS         = 8;
  localparam int unsigned TABLE_BITS        = 48;
  localparam int unsigned CFG_IDX_BITS      = 3;
  localparam int unsigned CFG_DATA_BITS     = 48;
  localparam int unsigned ACTION_BITS       = 3;
  localparam int unsigned MAX_RESULTS       = 3;
  localparam int unsigned SLOT_BITS         = 2;

  typedef logic [TICK_COUNTER_BITS-1:0] age_t;
  typedef logic [THRESH_BITS-1:0]       thresh_t;
  typedef logic [LEVEL_BITS-1:0]        level_t;
  typedef logic [DUTY_BITS-1:0]         duty_t;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_NONE    = 3'd0,
    ACT_DOWN    = 3'd1,
    ACT_SELECT  = 3'd2,
    ACT_SLEEP   = 3'd3,
    ACT_UP      = 3'd4,
    ACT_REFRESH = 3'd5
  } action_e;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAIN_LONG   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_GAP  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_LONG = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_TABLE  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_INVERT = 3'd5;

  localparam thresh_t                RST_DEBOUNCE    = 12'd2;
  localparam thresh_t                RST_MAIN_LONG   = 12'd35;
  localparam thresh_t                RST_DOUBLE_GAP  = 12'd13;
  localparam thresh_t                RST_SECOND_LONG = 12'd30;
  localparam logic [TABLE_BITS-1:0]  RST_DUTY_TABLE  = 48'h8040_180C_0800;

  typedef struct packed {
    action_e [MAX_RESULTS-1:0] acts;
    logic [SLOT_BITS-1:0]      last_idx;
    duty_t                     duty;
  } rec_t;

endpackage

@@ sv/tbgd_if.sv @@
// Valid/ready channel interfaces for tick words and result words.
interface tbgd_in_if;
  logic valid;
  logic ready;
  logic main_pressed;
  logic second_sample_valid;
  logic second_pressed;

  modport source (output valid, main_pressed, second_sample_valid, second_pressed,
                  input ready);
  modport sink (input valid, main_pressed, second_sample_valid, second_pressed,
                output ready);
endinterface

interface tbgd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] light_duty;
  logic       last;

  modport source (output valid, action, light_duty, last, input ready);
  modport sink (input valid, action, light_duty, last, output ready);
endinterface

@@ sv/two_button_gesture_decoder.sv @@
// Top level: two-button gesture decoder with light level control.
//
//   channel  dir  word                                        handshake
//   in_w     in   main_pressed, second_sample_valid,          valid/ready
//                 second_pressed
//   out_w    out  action, light_duty, last                    valid/ready
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i             write enable only
//
// One tick per cycle while ready; its 1 to 3 words leave one per cycle if taken.
// Decoder state updates at the accepting edge; results wait in a two-record queue.
// A result word appears at the earliest in the cycle after its tick word is taken.
// Input ready drops only when both queue records are occupied.
// Reset restores all register values and clears all state and the queue.
module two_button_gesture_decoder
  import tbgd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  tbgd_in_if.sink                  in_w,
  tbgd_out_if.source               out_w
);

  thresh_t                 debounce_q, main_long_q, gap_q, second_long_q;
  logic [TABLE_BITS-1:0]   table_q;
  logic                    invert_q;

  logic   main_prev_q, main_cons_q, main_tw_q;
  age_t   main_page_q, main_tage_q;
  logic   sec_cached_q, sec_prev_q, sec_cons_q, sec_tw_q;
  age_t   sec_page_q, sec_tage_q;
  level_t level_q;

  logic   main_prev_d, main_cons_d, main_tw_d;
  age_t   main_page_d, main_tage_d;
  logic   sec_cached_d, sec_prev_d, sec_cons_d, sec_tw_d;
  age_t   sec_page_d, sec_tage_d;
  level_t level_d;

  logic    s_v, m_v, d_v;
  action_e s_code, m_code;
  rec_t    rec_new;
  logic [SLOT_BITS-1:0] n_acts;
  duty_t   duty_raw;

  rec_t                 rec_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q;
  logic [SLOT_BITS-1:0] slot_q;
  rec_t                 head;
  logic                 in_fire, out_fire, pop_rec;

  function automatic age_t age_inc(input age_t a);
    return (a == '1) ? a : age_t'(a + 1'b1);
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= RST_DEBOUNCE;
      main_long_q   <= RST_MAIN_LONG;
      gap_q         <= RST_DOUBLE_GAP;
      second_long_q <= RST_SECOND_LONG;
      table_q       <= RST_DUTY_TABLE;
      invert_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE:    debounce_q    <= cfg_data_i[THRESH_BITS-1:0];
        REG_MAIN_LONG:   main_long_q   <= cfg_data_i[THRESH_BITS-1:0];
        REG_DOUBLE_GAP:  gap_q         <= cfg_data_i[THRESH_BITS-1:0];
        REG_SECOND_LONG: second_long_q <= cfg_data_i[THRESH_BITS-1:0];
        REG_DUTY_TABLE:  table_q       <= cfg_data_i[TABLE_BITS-1:0];
        REG_DUTY_INVERT: invert_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Tick decode
  always_comb begin
    sec_cached_d = in_w.second_sample_valid ? in_w.second_pressed : sec_cached_q;
    sec_page_d   = sec_prev_q ? age_inc(sec_page_q) : sec_page_q;
    sec_tage_d   = sec_tw_q ? age_inc(sec_tage_q) : sec_tage_q;
    main_page_d  = main_prev_q ? age_inc(main_page_q) : main_page_q;
    main_tage_d  = main_tw_q ? age_inc(main_tage_q) : main_tage_q;
    sec_cons_d   = sec_cons_q;
    sec_tw_d     = sec_tw_q;
    main_cons_d  = main_cons_q;
    main_tw_d    = main_tw_q;
    level_d      = level_q;
    s_v          = 1'b0;
    s_code       = ACT_NONE;
    m_v          = 1'b0;
    m_code       = ACT_NONE;
    d_v          = 1'b0;

    if (sec_cached_d && !sec_prev_q) begin
      sec_page_d = '0;
      sec_cons_d = 1'b0;
    end else if (sec_cached_d && sec_prev_q) begin
      if (!sec_cons_d && sec_page_d >= second_long_q) begin
        level_d    = '0;
        sec_cons_d = 1'b1;
      end
    end else if (!sec_cached_d && sec_prev_q) begin
      if (!sec_cons_d && sec_page_d >= debounce_q) begin
        if (sec_tw_d) begin
          sec_tw_d = 1'b0;
          s_v      = 1'b1;
          s_code   = ACT_REFRESH;
        end else begin
          sec_tw_d   = 1'b1;
          sec_tage_d = '0;
        end
      end
      sec_cons_d = 1'b0;
    end
    sec_prev_d = sec_cached_d;

    if (sec_tw_d && sec_tage_d >= gap_q) begin
      sec_tw_d = 1'b0;
      s_v      = 1'b1;
      s_code   = ACT_UP;
    end

    if (in_w.main_pressed && !main_prev_q) begin
      if (sec_cached_d) begin
        level_d     = (level_d == level_t'(LEVEL_COUNT - 1)) ? '0 : level_t'(level_d + 1'b1);
        main_cons_d = 1'b1;
        sec_cons_d  = 1'b1;
      end else begin
        main_page_d = '0;
        main_cons_d = 1'b0;
      end
    end else if (in_w.main_pressed && main_prev_q) begin
      if (!main_cons_d && !sec_cached_d && main_page_d >= main_long_q) begin
        m_v         = 1'b1;
        m_code      = ACT_SLEEP;
        main_cons_d = 1'b1;
      end
    end else if (!in_w.main_pressed && main_prev_q) begin
      if (!main_cons_d && main_page_d >= debounce_q) begin
        if (main_tw_d) begin
          main_tw_d = 1'b0;
          m_v       = 1'b1;
          m_code    = ACT_SELECT;
        end else begin
          main_tw_d   = 1'b1;
          main_tage_d = '0;
        end
      end
      main_cons_d = 1'b0;
    end
    main_prev_d = in_w.main_pressed;

    if (main_tw_d && main_tage_d >= gap_q) begin
      main_tw_d = 1'b0;
      d_v       = 1'b1;
    end
  end

  // Pack the tick's results in order: second button, main section, lone main tap
  always_comb begin
    n_acts   = SLOT_BITS'({1'b0, s_v}) + SLOT_BITS'({1'b0, m_v}) + SLOT_BITS'({1'b0, d_v});
    duty_raw = table_q[DUTY_BITS*level_d +: DUTY_BITS];
    rec_new.acts[0]  = s_v ? s_code : (m_v ? m_code : (d_v ? ACT_DOWN : ACT_NONE));
    rec_new.acts[1]  = (s_v && m_v) ? m_code : ACT_DOWN;
    rec_new.acts[2]  = ACT_DOWN;
    rec_new.last_idx = (n_acts == '0) ? '0 : SLOT_BITS'(n_acts - 1'b1);
    rec_new.duty     = invert_q ? ~duty_raw : duty_raw;
  end

  assign in_w.ready = (count_q != 2'd2);
  assign in_fire    = in_w.valid && in_w.ready;
  assign head       = rec_q[rd_ptr_q];
  assign out_fire   = out_w.valid && out_w.ready;
  assign pop_rec    = out_fire && (slot_q == head.last_idx);

  assign out_w.valid      = (count_q != 2'd0);
  assign out_w.action     = head.acts[slot_q];
  assign out_w.light_duty = head.duty;
  assign out_w.last       = (slot_q == head.last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_prev_q  <= 1'b0;
      main_page_q  <= '0;
      main_cons_q  <= 1'b0;
      main_tw_q    <= 1'b0;
      main_tage_q  <= '0;
      sec_cached_q <= 1'b0;
      sec_prev_q   <= 1'b0;
      sec_page_q   <= '0;
      sec_cons_q   <= 1'b0;
      sec_tw_q     <= 1'b0;
      sec_tage_q   <= '0;
      level_q      <= '0;
    end else if (in_fire) begin
      main_prev_q  <= main_prev_d;
      main_page_q  <= main_page_d;
      main_cons_q  <= main_cons_d;
      main_tw_q    <= main_tw_d;
      main_tage_q  <= main_tage_d;
      sec_cached_q <= sec_cached_d;
      sec_prev_q   <= sec_prev_d;
      sec_page_q   <= sec_page_d;
      sec_cons_q   <= sec_cons_d;
      sec_tw_q     <= sec_tw_d;
      sec_tage_q   <= sec_tage_d;
      level_q      <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rec_q[wr_ptr_q] <= rec_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      slot_q   <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_rec) begin
        rd_ptr_q <= ~rd_ptr_q;
        slot_q   <= '0;
      end else if (out_fire) begin
        slot_q <= SLOT_BITS'(slot_q + 1'b1);
      end
      case ({in_fire, pop_rec})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("result queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) level_q < level_t'(LEVEL_COUNT))
    else $error("light level out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_w.valid |-> slot_q <= head.last_idx)
    else $error("result slot beyond last of record");
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> count_q != 2'd0)
    else $error("accepted tick left no record");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_fire && !out_w.last) |=> (out_w.valid && slot_q != '0))
    else $error("record dropped before its last word");

endmodule
